/* hdl/trp_pkg.sv */
`timescale 1ns / 1ps

package trp_pkg;

  // Default number of task entries in the statistics table.
  localparam int TASK_SLOTS_DEF = 64;

  localparam int STAT_W  = 32;
  localparam int INDEX_W = 8;

  typedef enum logic {
    ACT_RECORD = 1'b0,
    ACT_READ   = 1'b1
  } action_t;

  // One command transaction.
  typedef struct packed {
    action_t             action;
    logic [INDEX_W-1:0]  task_index;
    logic [STAT_W-1:0]   run_ticks;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic                accepted;
    logic [STAT_W-1:0]   switch_count;
    logic [STAT_W-1:0]   runtime_sum;
    logic [STAT_W-1:0]   runtime_max;
    logic [STAT_W-1:0]   runtime_min;
    logic [STAT_W-1:0]   runtime_mean;
  } rsp_t;

  // One row of the statistics table.
  typedef struct packed {
    logic [STAT_W-1:0] switches;
    logic [STAT_W-1:0] total;
    logic [STAT_W-1:0] longest;
    logic [STAT_W-1:0] shortest;
    logic [STAT_W-1:0] mean;
  } row_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOK,
    ST_CALC,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

/* hdl/trp_table.sv */
`timescale 1ns / 1ps

module trp_table #(
  parameter int TASK_SLOTS = trp_pkg::TASK_SLOTS_DEF,
  parameter int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              clear,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output trp_pkg::row_t     rd_data,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  trp_pkg::row_t     wr_data
);

  trp_pkg::row_t           mem [TASK_SLOTS];
  trp_pkg::row_t           rd_q;
  logic [TASK_SLOTS-1:0]   vld;
  logic                    rd_vld;

  // Row storage; read data is registered.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // A row that has not been written since the last clear reads as zero.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

/* hdl/trp_divider.sv */
`timescale 1ns / 1ps

module trp_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [trp_pkg::STAT_W-1:0]   dividend,
  input  logic [trp_pkg::STAT_W-1:0]   divisor,
  output logic                         done,
  output logic [trp_pkg::STAT_W-1:0]   quotient
);

  localparam int W     = trp_pkg::STAT_W;
  localparam int CNT_W = $clog2(W);

  logic             running;
  logic [CNT_W-1:0] step;
  logic [W-1:0]     rem;
  logic [W-1:0]     quo;
  logic [W-1:0]     dvs;
  logic [W:0]       trial;

  // Restoring division, one quotient bit per cycle, MSB first.
  assign trial = {rem, quo[W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + CNT_W'(1);
        if (step == CNT_W'(W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (running) begin
      if (!trial[W]) begin
        rem <= trial[W-1:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= {rem[W-2:0], quo[W-1]};
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient = quo;

endmodule

/* hdl/task_runtime_profiler_core.sv */
`timescale 1ns / 1ps

// Channel   Signals                     Dir  Transfer
// -------   -------------------------   ---  ------------------------------------------
// command   start, cmd, busy            in   taken at a rising edge with start && !busy
// result    done, result                out  valid for one cycle while done is high
// config    cfg_we, cfg_wdata           in   profiling_on written at an edge with cfg_we
//
// A record transaction passes from the accepting edge through table lookup, update, 32 steps
// in the restoring divider for the mean, taking the quotient, and the result state, which
// also writes the row back. A read transaction goes from lookup straight to the result, a
// rejected one reads no row, and a record whose count wraps to zero skips the divide.
// Reset is synchronous and active high and empties the table at once through per-row valid
// bits, as does turning profiling on. The result receiver cannot stall, so done is a
// single-cycle strobe and busy alone paces the command side.

module task_runtime_profiler_core #(
  parameter int TASK_SLOTS = trp_pkg::TASK_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  trp_pkg::cmd_t  cmd,
  output logic           busy,
  output logic           done,
  output trp_pkg::rsp_t  result,
  input  logic           cfg_we,
  input  logic           cfg_wdata
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int W     = trp_pkg::STAT_W;

  trp_pkg::state_t  state;
  trp_pkg::state_t  state_next;

  // The profiling_on register; writing 1 while it reads 0 clears the table.
  logic profiling_on;
  logic table_clear;

  // Captured command transaction.
  trp_pkg::action_t     act;
  logic [IDX_W-1:0]     slot;
  logic [W-1:0]         ticks;
  logic                 ok;

  // Result under construction; it also supplies the row written back.
  trp_pkg::rsp_t res;
  trp_pkg::rsp_t res_next;
  logic          res_load;

  trp_pkg::row_t tbl_rdata;
  trp_pkg::row_t tbl_wdata;
  logic          tbl_rd_en;
  logic          tbl_wr_en;

  logic          div_start;
  logic          div_done;
  logic [W-1:0]  div_quotient;

  // Record update terms, formed from the row just read.
  logic [W-1:0]  cnt_new;
  logic [W-1:0]  sum_new;
  logic [W-1:0]  max_new;
  logic [W-1:0]  min_new;

  logic in_range;
  logic accept;

  assign accept      = start && !busy;
  assign in_range    = {1'b0, cmd.task_index} < (trp_pkg::INDEX_W + 1)'(TASK_SLOTS);
  assign table_clear = cfg_we && cfg_wdata && !profiling_on;

  always_ff @(posedge clk) begin
    if (rst) begin
      profiling_on <= 1'b0;
    end else if (cfg_we) begin
      profiling_on <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= trp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the command; an item is carried out only if its slot exists and,
  // for a record, profiling is on. Reads work even with profiling off.
  always_ff @(posedge clk) begin
    if (accept) begin
      act   <= cmd.action;
      slot  <= cmd.task_index[IDX_W-1:0];
      ticks <= cmd.run_ticks;
      ok    <= in_range && (cmd.action == trp_pkg::ACT_READ || profiling_on);
    end
    if (res_load) begin
      res <= res_next;
    end
  end

  assign cnt_new = tbl_rdata.switches + W'(1);
  assign sum_new = tbl_rdata.total + ticks;
  assign max_new = (ticks > tbl_rdata.longest) ? ticks : tbl_rdata.longest;
  // The minimum is also reloaded whenever the count comes back to one, which
  // covers the first record and the first record after the count wraps.
  assign min_new = (ticks < tbl_rdata.shortest || cnt_new == W'(1)) ? ticks
                                                                    : tbl_rdata.shortest;

  always_comb begin
    state_next = state;
    tbl_rd_en  = 1'b0;
    div_start  = 1'b0;
    res_load   = 1'b0;
    res_next   = res;
    unique case (state)
      trp_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = trp_pkg::ST_LOOK;
        end
      end
      trp_pkg::ST_LOOK: begin
        if (ok) begin
          tbl_rd_en  = 1'b1;
          state_next = trp_pkg::ST_CALC;
        end else begin
          // Rejected transactions report all-zero statistics.
          res_load   = 1'b1;
          res_next   = '0;
          state_next = trp_pkg::ST_DONE;
        end
      end
      trp_pkg::ST_CALC: begin
        res_load = 1'b1;
        res_next.accepted = 1'b1;
        if (act == trp_pkg::ACT_READ) begin
          res_next.switch_count = tbl_rdata.switches;
          res_next.runtime_sum  = tbl_rdata.total;
          res_next.runtime_max  = tbl_rdata.longest;
          res_next.runtime_min  = tbl_rdata.shortest;
          res_next.runtime_mean = tbl_rdata.mean;
          state_next            = trp_pkg::ST_DONE;
        end else begin
          res_next.switch_count = cnt_new;
          res_next.runtime_sum  = sum_new;
          res_next.runtime_max  = max_new;
          res_next.runtime_min  = min_new;
          res_next.runtime_mean = '0;
          // A count that wrapped to zero leaves the mean at zero.
          if (cnt_new != '0) begin
            div_start  = 1'b1;
            state_next = trp_pkg::ST_DIV;
          end else begin
            state_next = trp_pkg::ST_DONE;
          end
        end
      end
      trp_pkg::ST_DIV: begin
        if (div_done) begin
          res_load              = 1'b1;
          res_next.runtime_mean = div_quotient;
          state_next            = trp_pkg::ST_DONE;
        end
      end
      trp_pkg::ST_DONE: begin
        state_next = trp_pkg::ST_IDLE;
      end
      default: begin
        state_next = trp_pkg::ST_IDLE;
      end
    endcase
  end

  assign tbl_wr_en = (state == trp_pkg::ST_DONE) && res.accepted
                     && (act == trp_pkg::ACT_RECORD);

  assign tbl_wdata.switches = res.switch_count;
  assign tbl_wdata.total    = res.runtime_sum;
  assign tbl_wdata.longest  = res.runtime_max;
  assign tbl_wdata.shortest = res.runtime_min;
  assign tbl_wdata.mean     = res.runtime_mean;

  trp_table #(
    .TASK_SLOTS (TASK_SLOTS),
    .IDX_W      (IDX_W)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .clear   (table_clear),
    .rd_en   (tbl_rd_en),
    .rd_addr (slot),
    .rd_data (tbl_rdata),
    .wr_en   (tbl_wr_en),
    .wr_addr (slot),
    .wr_data (tbl_wdata)
  );

  // The divider is started with the updated total and count of the row.
  trp_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_new),
    .divisor  (cnt_new),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign busy   = (state != trp_pkg::ST_IDLE);
  assign done   = (state == trp_pkg::ST_DONE);
  assign result = res;

  // Every accepted command transaction keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block not busy after accepting a command");

  // The result strobe lasts exactly one cycle.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held longer than one cycle");

  // A rejected transaction reports zero statistics.
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.accepted) |-> (result.switch_count == '0 && result.runtime_sum == '0
      && result.runtime_max == '0 && result.runtime_min == '0
      && result.runtime_mean == '0))
    else $error("rejected result carries nonzero statistics");

  // The divider only finishes while the sequencer waits for it.
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == trp_pkg::ST_DIV))
    else $error("divider finished outside the divide step");

endmodule

/* sim/task_runtime_profiler_core_tb.sv */
`timescale 1ns / 1ps

// Self-checking bench for the task runtime profiler. Commands are driven at the falling edge
// and results are sampled at the rising edge. A small scoreboard keeps its own copy of the
// per-task statistics and of the profiling switch. It works out the expected result of every
// accepted command and compares each result strobe against the oldest expectation.

module task_runtime_profiler_core_tb;

  localparam int SLOTS      = trp_pkg::TASK_SLOTS_DEF;
  localparam int HALF_CYCLE = 2;
  // Cycles without any accepted transaction before the run is declared hung. This is far longer
  // than a record transaction plus a configuration pause, so far beyond any correct run.
  localparam int STALL_LIMIT = 2000;
  // Quiet time after the last result: longer than one full record transaction.
  localparam int DRAIN_CYCLES = 40;

  // Shadow of the statistics table. It predicts one result per accepted command.
  class runtime_stats_board;
    logic [trp_pkg::STAT_W-1:0] switches [SLOTS];
    logic [trp_pkg::STAT_W-1:0] total    [SLOTS];
    logic [trp_pkg::STAT_W-1:0] longest  [SLOTS];
    logic [trp_pkg::STAT_W-1:0] shortest [SLOTS];
    logic [trp_pkg::STAT_W-1:0] mean     [SLOTS];
    bit   enabled;
    trp_pkg::rsp_t expected_entries[$];
    int   failures;

    function new();
      clear_rows();
      enabled  = 1'b0;
      failures = 0;
    endfunction

    function void clear_rows();
      foreach (switches[i]) begin
        switches[i] = '0;
        total[i]    = '0;
        longest[i]  = '0;
        shortest[i] = '0;
        mean[i]     = '0;
      end
    endfunction

    // Only a rising edge of the enable wipes the table. Turning it off keeps the table readable.
    function void set_profiling(bit on);
      if (on && !enabled) clear_rows();
      enabled = on;
    endfunction

    function void note_command(trp_pkg::cmd_t c);
      trp_pkg::rsp_t              r;
      logic [trp_pkg::STAT_W-1:0] cnt;
      logic [trp_pkg::STAT_W-1:0] sum;
      r = '0;
      if (c.task_index < SLOTS && (c.action == trp_pkg::ACT_READ || enabled)) begin
        if (c.action == trp_pkg::ACT_RECORD) begin
          cnt = switches[c.task_index] + 1;
          sum = total[c.task_index] + c.run_ticks;
          switches[c.task_index] = cnt;
          total[c.task_index]    = sum;
          if (c.run_ticks > longest[c.task_index]) longest[c.task_index] = c.run_ticks;
          // The first record after a clear (or after the count wraps) always sets the minimum.
          if (c.run_ticks < shortest[c.task_index] || cnt == 1)
            shortest[c.task_index] = c.run_ticks;
          mean[c.task_index] = (cnt != 0) ? sum / cnt : '0;
        end
        r.accepted     = 1'b1;
        r.switch_count = switches[c.task_index];
        r.runtime_sum  = total[c.task_index];
        r.runtime_max  = longest[c.task_index];
        r.runtime_min  = shortest[c.task_index];
        r.runtime_mean = mean[c.task_index];
      end
      expected_entries.push_back(r);
    endfunction

    function void compare_field(string name, logic [trp_pkg::STAT_W-1:0] want,
                                logic [trp_pkg::STAT_W-1:0] got);
      if (got !== want) begin
        failures++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(trp_pkg::rsp_t got);
      trp_pkg::rsp_t want;
      if (expected_entries.size() == 0) begin
        failures++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        return;
      end
      want = expected_entries.pop_front();
      compare_field("accepted", trp_pkg::STAT_W'(want.accepted),
                    trp_pkg::STAT_W'(got.accepted));
      compare_field("switch_count", want.switch_count, got.switch_count);
      compare_field("runtime_sum", want.runtime_sum, got.runtime_sum);
      compare_field("runtime_max", want.runtime_max, got.runtime_max);
      compare_field("runtime_min", want.runtime_min, got.runtime_min);
      compare_field("runtime_mean", want.runtime_mean, got.runtime_mean);
    endfunction

    function int pending();
      return expected_entries.size();
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst;
  logic          start;
  trp_pkg::cmd_t cmd;
  logic          busy;
  logic          done;
  trp_pkg::rsp_t result;
  logic          cfg_we;
  logic          cfg_wdata;

  runtime_stats_board stats = new();

  // When set, the command side issues back to back with no idle cycles.
  bit no_gaps;
  int quiet_cycles = 0;

  task_runtime_profiler_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #(HALF_CYCLE) clk = ~clk;

  // The result side cannot stall, so every strobe is a transaction that must be checked.
  always @(posedge clk) begin
    if (!rst && done) stats.check_result(result);
  end

  // The watchdog restarts whenever either side completes a transaction.
  always @(posedge clk) begin
    if ((start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Holds start for one command until the block takes it. A gap of zero leaves start high from
  // the previous command, so start never drops and rises within the same falling edge.
  task automatic issue_cmd(input trp_pkg::action_t act, input int idx,
                           input logic [trp_pkg::STAT_W-1:0] ticks);
    trp_pkg::cmd_t c;
    int            gap;
    c.action     = act;
    c.task_index = idx[trp_pkg::INDEX_W-1:0];
    c.run_ticks  = ticks;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    do @(posedge clk); while (busy);
    stats.note_command(c);
  endtask

  // Waits until the block is idle, then writes the enable. The predictor follows at the same
  // edge at which the block takes the write.
  task automatic write_profiling(input logic on);
    @(negedge clk);
    start <= 1'b0;
    while (stats.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= on;
    @(posedge clk);
    stats.set_profiling(on);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random commands lean on a few hot tasks so that counts, sums and minimums build up, with
  // a share of out of range indexes and extreme run lengths so that sums wrap.
  task automatic random_cmd();
    trp_pkg::action_t           act;
    int                         idx;
    logic [trp_pkg::STAT_W-1:0] ticks;
    int                         pick;
    act  = ($urandom_range(0, 3) == 0) ? trp_pkg::ACT_READ : trp_pkg::ACT_RECORD;
    pick = $urandom_range(0, 19);
    if (pick < 10)      idx = $urandom_range(0, 5);
    else if (pick < 17) idx = $urandom_range(0, SLOTS - 1);
    else if (pick < 18) idx = SLOTS - 1;
    else                idx = $urandom_range(SLOTS, 255);
    case ($urandom_range(0, 4))
      0: ticks = $urandom_range(0, 1000);
      1: ticks = $urandom;
      2: ticks = 32'hFFFF_FFFF - $urandom_range(0, 15);
      3: ticks = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: ticks = 32'h1 << $urandom_range(0, 31);
    endcase
    issue_cmd(act, idx, ticks);
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    cmd          = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    no_gaps      = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Profiling is off after reset: records are refused, reads in range still return the
    // (empty) entry, and an out of range read is refused.
    issue_cmd(trp_pkg::ACT_RECORD, 5, 32'd77);
    issue_cmd(trp_pkg::ACT_READ, 0, 32'h0);
    issue_cmd(trp_pkg::ACT_READ, 255, 32'hFFFF_FFFF);

    // Writing zero while already off changes nothing; the first enable clears the table.
    write_profiling(1'b0);
    write_profiling(1'b1);

    // First record sets the minimum, then the extremes of run length, a wrapping sum on the
    // last slot, and a later smaller value that lowers the minimum.
    issue_cmd(trp_pkg::ACT_RECORD, 0, 32'h0);
    issue_cmd(trp_pkg::ACT_RECORD, 0, 32'hFFFF_FFFF);
    issue_cmd(trp_pkg::ACT_RECORD, SLOTS - 1, 32'hFFFF_FFFF);
    issue_cmd(trp_pkg::ACT_RECORD, SLOTS - 1, 32'hFFFF_FFFF);
    issue_cmd(trp_pkg::ACT_RECORD, SLOTS - 1, 32'd5);
    // Indexes at and far above the table depth are refused for both actions.
    issue_cmd(trp_pkg::ACT_RECORD, SLOTS, 32'd1);
    issue_cmd(trp_pkg::ACT_RECORD, 255, 32'hFFFF_FFFF);
    issue_cmd(trp_pkg::ACT_READ, SLOTS - 1, 32'h0);
    issue_cmd(trp_pkg::ACT_READ, SLOTS, 32'h0);

    // Enabling while already on keeps the table.
    write_profiling(1'b1);
    issue_cmd(trp_pkg::ACT_READ, SLOTS - 1, 32'h5555_AAAA);

    // Turning off stops recording but the table can still be read.
    write_profiling(1'b0);
    issue_cmd(trp_pkg::ACT_RECORD, SLOTS - 1, 32'd1);
    issue_cmd(trp_pkg::ACT_READ, SLOTS - 1, 32'h0);

    // Turning on again from off wipes everything.
    write_profiling(1'b1);
    issue_cmd(trp_pkg::ACT_READ, SLOTS - 1, 32'h0);
    issue_cmd(trp_pkg::ACT_RECORD, SLOTS - 1, 32'hAAAA_5555);
    issue_cmd(trp_pkg::ACT_READ, SLOTS - 1, 32'h55AA_AA55);

    // Random phases, each under its own setting of the enable. Most phases record; an
    // occasional off phase checks that records are refused while reads still work, and an
    // off-on pair clears the table in the middle of the run.
    for (int phase = 0; phase < 7; phase++) begin
      case ($urandom_range(0, 5))
        0: write_profiling(1'b0);
        1: begin
          write_profiling(1'b0);
          write_profiling(1'b1);
        end
        default: write_profiling(1'b1);
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (100) random_cmd();
    end

    @(negedge clk);
    start <= 1'b0;
    while (stats.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (stats.failures == 0 && stats.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
